FILE: rtl/ptc_pkg.sv
// shared types and constants for the pressure and temperature compensation block
// no dependencies
`timescale 1ns / 1ps

package ptc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgCalTemp   = 2'd0,
    CfgCalPressA = 2'd1,
    CfgCalPressB = 2'd2,
    CfgCalPressC = 2'd3
  } ptc_cfg_e;

  localparam int unsigned CfgWidth = 64;

  // divider: radix-4 restoring, two quotient bits per stage
  localparam int unsigned DivBits  = 2;
  localparam int unsigned DivWidth = 64;
  localparam int unsigned DivSteps = DivWidth / DivBits;
  localparam int unsigned DenWidth = 31;

  localparam logic [26:0] FineOffset = 27'd128000;
  localparam logic [20:0] PcodeFull  = 21'd1048576;
  localparam logic [11:0] Pscale     = 12'd3125;
  localparam logic [24:0] PressMax   = 25'h1FFFFFF;

  typedef struct packed {
    logic [19:0] temp_code;
    logic [19:0] press_code;
  } ptc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [24:0]        pressure_q24_8;
    logic               divisor_zero;
  } ptc_out_t;

  // data riding alongside the divider
  typedef struct packed {
    logic signed [15:0] temp;
    logic               dz;
    logic               neg;
  } ptc_side_t;

endpackage

FILE: rtl/ptc_div.sv
// pipelined unsigned 64 by 31 bit divider, two quotient bits per stage
// depends on ptc_pkg
`timescale 1ns / 1ps

module ptc_div import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [DivWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  input  ptc_side_t           side_i,
  output logic                vld_o,
  output logic [DivWidth-1:0] quo_o,
  output ptc_side_t           side_o
);

  logic [DivSteps:0]   vld_q;
  logic [DenWidth-1:0] rem_q  [DivSteps+1];
  logic [DivWidth-1:0] nq_q   [DivSteps+1];
  logic [DenWidth-1:0] den_q  [DivSteps+1];
  ptc_side_t           side_q [DivSteps+1];

  // one restoring step: shift in a dividend bit, subtract when it fits
  function automatic logic [DenWidth+DivWidth-1:0] div_step(
    input logic [DenWidth-1:0] rem,
    input logic [DivWidth-1:0] nq,
    input logic [DenWidth-1:0] den
  );
    logic [DenWidth:0]   r2;
    logic                ge;
    logic [DenWidth:0]   diff;
    logic [DenWidth-1:0] rn;
    r2   = {rem, nq[DivWidth-1]};
    ge   = (r2 >= {1'b0, den});
    diff = r2 - {1'b0, den};
    rn   = ge ? diff[DenWidth-1:0] : r2[DenWidth-1:0];
    return {rn, nq[DivWidth-2:0], ge};
  endfunction

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivSteps-1:0], vld_i};
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    nq_q[0]   <= num_i;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
  end

  // step stages
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [DenWidth+DivWidth-1:0] s1;
    logic [DenWidth+DivWidth-1:0] s2;

    always_comb begin
      s1 = div_step(rem_q[k], nq_q[k], den_q[k]);
      s2 = div_step(s1[DenWidth+DivWidth-1:DivWidth], s1[DivWidth-1:0], den_q[k]);
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= s2[DenWidth+DivWidth-1:DivWidth];
      nq_q[k+1]   <= s2[DivWidth-1:0];
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign vld_o  = vld_q[DivSteps];
  assign quo_o  = nq_q[DivSteps];
  assign side_o = side_q[DivSteps];

endmodule

FILE: rtl/pressure_temp_compensation.sv
// top level: temperature and pressure compensation pipeline with config registers
// depends on ptc_pkg and ptc_div
`timescale 1ns / 1ps

// Takes one raw temperature and pressure code pair in every clock cycle (busy_o
// stays low) and gives each result for one cycle, marked by res_valid_o; the
// receiver cannot stall, so the caller must take every result when it appears.
// The pipeline is made up of the 64-bit signed division, which runs as 32
// pipeline stages of two quotient bits each, plus the multiply stages before
// and after it. Calibration registers may only be written while no item is
// in flight.
module pressure_temp_compensation import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ptc_in_t             in_i,
  output logic                res_valid_o,
  output ptc_out_t            res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  // calibration registers
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [15:0] cal_press_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_press_c_q <= '0;
    end else if (cfg_we_i) begin
      case (ptc_cfg_e'(cfg_addr_i))
        CfgCalTemp:   cal_temp_q    <= cfg_wdata_i[47:0];
        CfgCalPressA: cal_press_a_q <= cfg_wdata_i;
        CfgCalPressB: cal_press_b_q <= cfg_wdata_i;
        CfgCalPressC: cal_press_c_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_temp_q[15:0];
  assign t2 = $signed(cal_temp_q[31:16]);
  assign t3 = $signed(cal_temp_q[47:32]);
  assign p1 = cal_press_a_q[15:0];
  assign p2 = $signed(cal_press_a_q[31:16]);
  assign p3 = $signed(cal_press_a_q[47:32]);
  assign p4 = $signed(cal_press_a_q[63:48]);
  assign p5 = $signed(cal_press_b_q[15:0]);
  assign p6 = $signed(cal_press_b_q[31:16]);
  assign p7 = $signed(cal_press_b_q[47:32]);
  assign p8 = $signed(cal_press_b_q[63:48]);
  assign p9 = $signed(cal_press_c_q);

  assign busy_o = 1'b0;

  // valid bits of the stages around the divider
  logic [7:0] pre_vld_q;
  logic [4:0] post_vld_q;

  // input stage
  ptc_in_t in_q;
  always_ff @(posedge clk_i) begin
    in_q <= in_i;
  end

  // stage 1: offsets and first temperature products
  logic signed [18:0] a_s;
  logic signed [16:0] b_s;
  logic signed [34:0] s1_at_d, s1_at_q;
  logic signed [34:0] s1_bb_d, s1_bb_q;
  logic [19:0]        s1_pc_q;

  always_comb begin
    a_s     = $signed({2'b00, in_q.temp_code[19:3]}) - $signed({2'b00, t1, 1'b0});
    b_s     = $signed({1'b0, in_q.temp_code[19:4]}) - $signed({1'b0, t1});
    s1_at_d = a_s * t2;
    s1_bb_d = b_s * b_s;
  end

  always_ff @(posedge clk_i) begin
    s1_at_q <= s1_at_d;
    s1_bb_q <= s1_bb_d;
    s1_pc_q <= in_q.press_code;
  end

  // stage 2: second temperature term
  logic signed [38:0] s2_pr_d, s2_pr_q;
  logic signed [26:0] s2_f1_q;
  logic signed [22:0] bbs;
  logic [19:0]        s2_pc_q;

  always_comb begin
    bbs     = $signed({1'b0, s1_bb_q[33:12]});
    s2_pr_d = bbs * t3;
  end

  always_ff @(posedge clk_i) begin
    s2_pr_q <= s2_pr_d;
    s2_f1_q <= 27'(s1_at_q >>> 11);
    s2_pc_q <= s1_pc_q;
  end

  // stage 3: fine temperature
  logic signed [26:0] s3_fine_q;
  logic [19:0]        s3_pc_q;

  always_ff @(posedge clk_i) begin
    s3_fine_q <= s2_f1_q + 27'(s2_pr_q >>> 14);
    s3_pc_q   <= s2_pc_q;
  end

  // stage 4: temperature output and first pressure products
  logic signed [29:0] t30;
  logic signed [21:0] t22;
  logic signed [15:0] s4_temp_d, s4_temp_q;
  logic signed [27:0] xv;
  logic signed [63:0] s4_xx_q, s4_xp5_q, s4_xp2_q;
  logic [19:0]        s4_pc_q;

  always_comb begin
    t30 = 30'(s3_fine_q) * 30'sd5 + 30'sd128;
    t22 = 22'(t30 >>> 8);
    if (t22 < -22'sd32768) begin
      s4_temp_d = -16'sd32768;
    end else if (t22 > 22'sd32767) begin
      s4_temp_d = 16'sd32767;
    end else begin
      s4_temp_d = t22[15:0];
    end
    xv = 28'(s3_fine_q) - $signed({1'b0, FineOffset});
  end

  always_ff @(posedge clk_i) begin
    s4_temp_q <= s4_temp_d;
    s4_xx_q   <= 64'(xv) * 64'(xv);
    s4_xp5_q  <= 64'(xv) * 64'(p5);
    s4_xp2_q  <= 64'(xv) * 64'(p2);
    s4_pc_q   <= s3_pc_q;
  end

  // stage 5: y term and divisor polynomial
  logic signed [63:0] s5_y_q, s5_xs_q;
  logic signed [15:0] s5_temp_q;
  logic [19:0]        s5_pc_q;

  always_ff @(posedge clk_i) begin
    s5_y_q    <= s4_xx_q * 64'(p6) + (s4_xp5_q <<< 17) + (64'(p4) <<< 35);
    s5_xs_q   <= ((s4_xx_q * 64'(p3)) >>> 8) + (s4_xp2_q <<< 12);
    s5_temp_q <= s4_temp_q;
    s5_pc_q   <= s4_pc_q;
  end

  // stage 6: scale by p1
  logic signed [63:0] s6_v_q, s6_y_q;
  logic signed [15:0] s6_temp_q;
  logic [19:0]        s6_pc_q;

  always_ff @(posedge clk_i) begin
    s6_v_q    <= (s5_xs_q + 64'sh0000_8000_0000_0000) * $signed({48'd0, p1});
    s6_y_q    <= s5_y_q;
    s6_temp_q <= s5_temp_q;
    s6_pc_q   <= s5_pc_q;
  end

  // stage 7: numerator and divisor
  logic [20:0]         pcd;
  logic [63:0]         s7_num_q;
  logic signed [30:0]  s7_den_q;
  logic                s7_dz_q;
  logic signed [15:0]  s7_temp_q;

  assign pcd = PcodeFull - {1'b0, s6_pc_q};

  always_ff @(posedge clk_i) begin
    s7_num_q  <= (({43'd0, pcd} << 31) - s6_y_q) * {52'd0, Pscale};
    s7_den_q  <= s6_v_q[63:33];
    s7_dz_q   <= (s6_v_q[63:33] == '0);
    s7_temp_q <= s6_temp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else begin
      pre_vld_q <= {pre_vld_q[6:0], start_i & ~busy_o};
    end
  end

  // magnitudes into the divider
  logic                nneg, dneg;
  logic [63:0]         mn;
  logic [DenWidth-1:0] md;
  ptc_side_t           div_side_in, div_side_out;
  logic                div_vld;
  logic [63:0]         div_quo;

  always_comb begin
    nneg             = s7_num_q[63];
    dneg             = s7_den_q[30];
    mn               = nneg ? (64'd0 - s7_num_q) : s7_num_q;
    md               = dneg ? (31'd0 - s7_den_q) : s7_den_q;
    div_side_in.temp = s7_temp_q;
    div_side_in.dz   = s7_dz_q;
    div_side_in.neg  = nneg ^ dneg;
  end

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pre_vld_q[7]),
    .num_i  (mn),
    .den_i  (md),
    .side_i (div_side_in),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q <= '0;
    end else begin
      post_vld_q <= {post_vld_q[3:0], div_vld};
    end
  end

  // stage a: quotient sign
  logic signed [63:0] sa_p_q;
  ptc_side_t          sa_side_q;

  always_ff @(posedge clk_i) begin
    sa_p_q    <= div_side_out.neg ? (64'sd0 - $signed(div_quo)) : $signed(div_quo);
    sa_side_q <= div_side_out;
  end

  // stage b: first correction products
  logic signed [63:0] sb_p_q, sb_ps_q, sb_m1_q, sb_m2_q;
  ptc_side_t          sb_side_q;

  always_ff @(posedge clk_i) begin
    sb_p_q    <= sa_p_q;
    sb_ps_q   <= sa_p_q >>> 13;
    sb_m1_q   <= 64'(p9) * (sa_p_q >>> 13);
    sb_m2_q   <= 64'(p8) * sa_p_q;
    sb_side_q <= sa_side_q;
  end

  // stage c: 64 by 64 low product as 32 by 32 partial products
  logic [63:0]        sc_ll_q;
  logic [31:0]        sc_lh_q, sc_hl_q;
  logic signed [63:0] sc_p_q, sc_q2_q;
  ptc_side_t          sc_side_q;

  always_ff @(posedge clk_i) begin
    sc_ll_q   <= {32'd0, sb_m1_q[31:0]} * {32'd0, sb_ps_q[31:0]};
    sc_lh_q   <= sb_m1_q[31:0] * sb_ps_q[63:32];
    sc_hl_q   <= sb_m1_q[63:32] * sb_ps_q[31:0];
    sc_p_q    <= sb_p_q;
    sc_q2_q   <= sb_m2_q >>> 19;
    sc_side_q <= sb_side_q;
  end

  // stage d: q1 term
  logic [63:0]        prod;
  logic signed [63:0] sd_q1_q, sd_p_q, sd_q2_q;
  ptc_side_t          sd_side_q;

  assign prod = sc_ll_q + {sc_lh_q + sc_hl_q, 32'd0};

  always_ff @(posedge clk_i) begin
    sd_q1_q   <= $signed(prod) >>> 25;
    sd_p_q    <= sc_p_q;
    sd_q2_q   <= sc_q2_q;
    sd_side_q <= sc_side_q;
  end

  // output stage: final sum and saturation
  logic signed [63:0] rsum;
  ptc_out_t           res_d, res_q;

  always_comb begin
    rsum = ((sd_p_q + sd_q1_q + sd_q2_q) >>> 8) + (64'(p7) <<< 4);
    res_d.temperature_centi = sd_side_q.temp;
    res_d.divisor_zero      = sd_side_q.dz;
    if (sd_side_q.dz || rsum[63]) begin
      res_d.pressure_q24_8 = '0;
    end else if (rsum > $signed({39'd0, PressMax})) begin
      res_d.pressure_q24_8 = PressMax;
    end else begin
      res_d.pressure_q24_8 = rsum[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = post_vld_q[4];
  assign res_o       = res_q;

endmodule
